/* rtl/lsfx_pkg.sv */
package lsfx_pkg;

	localparam int LED_COUNT_DEF = 16;

	localparam int IDX_OUT_W = 6;
	localparam int PHASE_W   = 9;
	localparam int COLOR_W   = 24;
	localparam int CFG_IDX_W = 2;

	// effect_mode codes; 5..7 fall back to solid
	localparam logic [2:0] MODE_SOLID   = 3'd0;
	localparam logic [2:0] MODE_RUN     = 3'd1;
	localparam logic [2:0] MODE_BREATHE = 3'd2;
	localparam logic [2:0] MODE_RAINBOW = 3'd3;
	localparam logic [2:0] MODE_BLINK   = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRB   = 2'd2;

	// one pixel request from the frame sequencer to the color datapath
	typedef struct packed {
		logic [IDX_OUT_W-1:0] led;
		logic [PHASE_W-1:0]   phase;
		logic                 last;
	} pix_req_t;

endpackage

/* rtl/lsfx_color.sv */
module lsfx_color #(
	parameter int LED_COUNT = lsfx_pkg::LED_COUNT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 advance,
	input  logic                                 req_valid,
	input  lsfx_pkg::pix_req_t                   req,
	input  logic [2:0]                           mode,
	input  logic [lsfx_pkg::COLOR_W-1:0]         base_color,
	input  logic                                 grb_order,
	output logic                                 out_valid,
	output logic [lsfx_pkg::IDX_OUT_W-1:0]       out_led,
	output logic [lsfx_pkg::COLOR_W-1:0]         out_color,
	output logic                                 out_last
);

	// rainbow hue offset for each LED position
	logic [7:0] wheel_off [64];
	for (genvar k = 0; k < 64; k++) begin : g_off
		assign wheel_off[k] = 8'((k * 256) / LED_COUNT);
	end

	logic [7:0]  wp;
	logic [7:0]  seg_w;
	logic [7:0]  seg_t;
	logic [23:0] wheel_c;
	logic [7:0]  bright;
	logic [23:0] plain_c;

	always_comb begin
		wp = wheel_off[req.led] + req.phase[7:0];
		if (wp < 8'd85) begin
			seg_w = wp;
		end else if (wp < 8'd170) begin
			seg_w = wp - 8'd85;
		end else begin
			seg_w = wp - 8'd170;
		end
		seg_t = 8'({1'b0, seg_w, 1'b0} + {2'b00, seg_w});
		if (wp < 8'd85) begin
			wheel_c = {8'd255 - seg_t, seg_t, 8'd0};
		end else if (wp < 8'd170) begin
			wheel_c = {8'd0, 8'd255 - seg_t, seg_t};
		end else begin
			wheel_c = {seg_t, 8'd0, 8'd255 - seg_t};
		end

		// triangle ramp: 511 - e == ~e[7:0] on the falling half
		bright = req.phase[8] ? ~req.phase[7:0] : req.phase[7:0];

		case (mode)
			lsfx_pkg::MODE_RUN:
				plain_c = ({3'b000, req.led} == req.phase) ? base_color : '0;
			lsfx_pkg::MODE_RAINBOW:
				plain_c = wheel_c;
			lsfx_pkg::MODE_BLINK:
				plain_c = (req.phase == '0) ? base_color : '0;
			default:
				plain_c = base_color;
		endcase
	end

	// stage 1: channel products and non-scaled color
	logic                              valid_s1;
	logic [lsfx_pkg::IDX_OUT_W-1:0]    led_s1;
	logic                              last_s1;
	logic                              breathe_s1;
	logic [23:0]                       color_s1;
	logic [15:0]                       prod_r_s1;
	logic [15:0]                       prod_g_s1;
	logic [15:0]                       prod_b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			led_s1     <= req.led;
			last_s1    <= req.last;
			breathe_s1 <= (mode == lsfx_pkg::MODE_BREATHE);
			color_s1   <= plain_c;
			prod_r_s1  <= base_color[23:16] * bright;
			prod_g_s1  <= base_color[15:8] * bright;
			prod_b_s1  <= base_color[7:0] * bright;
		end
	end

	// x / 255 for x <= 65025 (any product of two bytes): (x + (x >> 8) + 1) >> 8
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] s;
		s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return s[15:8];
	endfunction

	logic [23:0] final_c;

	always_comb begin
		final_c = breathe_s1 ?
			{div255(prod_r_s1), div255(prod_g_s1), div255(prod_b_s1)} : color_s1;
		if (grb_order) begin
			final_c = {final_c[15:8], final_c[23:16], final_c[7:0]};
		end
	end

	// stage 2: output register
	logic                              valid_s2;
	logic [lsfx_pkg::IDX_OUT_W-1:0]    led_s2;
	logic [23:0]                       color_s2;
	logic                              last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			led_s2   <= led_s1;
			color_s2 <= final_c;
			last_s2  <= last_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_led   = led_s2;
	assign out_color = color_s2;
	assign out_last  = last_s2;

endmodule

/* rtl/led_strip_effect_generator.sv */
// Channel  | Direction | Handshake            | Payload
// tick     | in        | tick_valid/stall     | restart
// pixel    | out       | pixel_valid/stall    | led_index, pixel_color, last
// cfg      | in        | cfg_write            | cfg_index, cfg_data
//
// One tick transaction yields LED_COUNT pixel transactions, one per cycle unless stalled;
// the frame sequencer's LED counter sets that figure. Pixels leave through
// the stage 1 and stage 2 registers. The next tick is taken in the cycle the
// last LED of the current frame is issued, so frames run back to back.
// A pixel stall with pixel_valid high freezes the whole pixel pipeline and the sequencer.
// Reset clears the phase, the config registers and all valid flags.
module led_strip_effect_generator #(
	parameter int LED_COUNT = lsfx_pkg::LED_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                tick_valid,
	output logic                                tick_stall,
	input  logic                                restart,
	output logic                                pixel_valid,
	input  logic                                pixel_stall,
	output logic [lsfx_pkg::IDX_OUT_W-1:0]      led_index,
	output logic [lsfx_pkg::COLOR_W-1:0]        pixel_color,
	output logic                                last,
	input  logic                                cfg_write,
	input  logic [lsfx_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lsfx_pkg::COLOR_W-1:0]        cfg_data
);

	localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_LED = IDX_W'(LED_COUNT - 1);

	// configuration registers
	logic [2:0]                         mode_q;
	logic [lsfx_pkg::COLOR_W-1:0]       color_q;
	logic                               grb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= lsfx_pkg::MODE_SOLID;
			color_q <= '0;
			grb_q   <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				lsfx_pkg::CFG_MODE:  mode_q  <= cfg_data[2:0];
				lsfx_pkg::CFG_COLOR: color_q <= cfg_data;
				lsfx_pkg::CFG_GRB:   grb_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// phase mod LED_COUNT: split into 64-blocks, table each part, one fixup
	logic [IDX_W-1:0] lo_mod [64];
	logic [IDX_W-1:0] hi_mod [8];
	for (genvar k = 0; k < 64; k++) begin : g_lo
		assign lo_mod[k] = IDX_W'(k % LED_COUNT);
	end
	for (genvar k = 0; k < 8; k++) begin : g_hi
		assign hi_mod[k] = IDX_W'((k * 64) % LED_COUNT);
	end

	logic [lsfx_pkg::PHASE_W-1:0] phase_q;
	logic [lsfx_pkg::PHASE_W-1:0] e_q;
	logic [IDX_W-1:0]             led_q;
	logic                         busy_q;

	logic [IDX_W:0]               mod_sum;
	logic [IDX_W-1:0]             run_e;
	logic [lsfx_pkg::PHASE_W-1:0] e_new;
	logic [lsfx_pkg::PHASE_W-1:0] phase_next;

	always_comb begin
		mod_sum = {1'b0, lo_mod[phase_q[5:0]]} + {1'b0, hi_mod[phase_q[8:6]]};
		if (mod_sum >= (IDX_W + 1)'(LED_COUNT)) begin
			mod_sum = mod_sum - (IDX_W + 1)'(LED_COUNT);
		end
		run_e = mod_sum[IDX_W-1:0];

		if (restart) begin
			e_new = '0;
		end else begin
			case (mode_q)
				lsfx_pkg::MODE_RUN:     e_new = lsfx_pkg::PHASE_W'(run_e);
				lsfx_pkg::MODE_BREATHE: e_new = phase_q;
				lsfx_pkg::MODE_RAINBOW: e_new = {1'b0, phase_q[7:0]};
				lsfx_pkg::MODE_BLINK:   e_new = {8'd0, phase_q[0]};
				default:                e_new = '0;
			endcase
		end

		case (mode_q)
			lsfx_pkg::MODE_RUN:
				phase_next = (e_new == lsfx_pkg::PHASE_W'(LED_COUNT - 1)) ?
					'0 : e_new + 1'b1;
			lsfx_pkg::MODE_BREATHE:
				phase_next = e_new + 1'b1;
			lsfx_pkg::MODE_RAINBOW:
				phase_next = {1'b0, e_new[7:0] + 8'd1};
			lsfx_pkg::MODE_BLINK:
				phase_next = {8'd0, ~e_new[0]};
			default:
				phase_next = '0;
		endcase
	end

	logic advance;
	logic issue;
	logic last_led;
	logic accept;

	assign advance    = !pixel_valid || !pixel_stall;
	assign issue      = busy_q && advance;
	assign last_led   = (led_q == LAST_LED);
	assign tick_stall = busy_q && !(issue && last_led);
	assign accept     = tick_valid && !tick_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			busy_q  <= 1'b0;
			led_q   <= '0;
			e_q     <= '0;
		end else if (accept) begin
			phase_q <= phase_next;
			busy_q  <= 1'b1;
			led_q   <= '0;
			e_q     <= e_new;
		end else if (issue) begin
			if (last_led) begin
				busy_q <= 1'b0;
			end else begin
				led_q <= led_q + 1'b1;
			end
		end
	end

	lsfx_pkg::pix_req_t req;

	always_comb begin
		req.led   = lsfx_pkg::IDX_OUT_W'(led_q);
		req.phase = e_q;
		req.last  = last_led;
	end

	lsfx_color #(
		.LED_COUNT(LED_COUNT)
	) u_color (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.req_valid  (issue),
		.req        (req),
		.mode       (mode_q),
		.base_color (color_q),
		.grb_order  (grb_q),
		.out_valid  (pixel_valid),
		.out_led    (led_index),
		.out_color  (pixel_color),
		.out_last   (last)
	);

endmodule

/* sim/led_strip_effect_generator_test.sv */
module led_strip_effect_generator_test;
	import lsfx_pkg::*;

	localparam int LED_N = LED_COUNT_DEF;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;	// unmapped register slot
	localparam int MAX_SHOWN = 10;
	localparam int SETTLE = 4;
	localparam int BREATH_RUN = 150;

	typedef struct packed {
		logic [IDX_OUT_W-1:0] led;
		logic [COLOR_W-1:0]   color;
		logic                 last;
	} lamp_t;

	typedef struct packed {
		bit                 cfg;
		logic [2:0]         mode;
		logic [COLOR_W-1:0] color;
		bit                 grb;
		bit                 rs;
		bit                 typed;
		logic [COLOR_W-1:0] want;
	} step_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 tick_valid;
	logic                 tick_stall;
	logic                 restart;
	logic                 pixel_valid;
	logic                 pixel_stall;
	logic [IDX_OUT_W-1:0] led_index;
	logic [COLOR_W-1:0]   pixel_color;
	logic                 last;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COLOR_W-1:0]   cfg_data;

	// effect state as the block should hold it
	logic [2:0]         fx_mode;
	logic [COLOR_W-1:0] fx_color;
	bit                 fx_grb;
	int                 fx_phase;

	lamp_t lamps_due[$];
	step_t plan[$];
	int    faults = 0;
	bit    tx_calm = 1'b0;
	bit    rx_calm = 1'b0;

	led_strip_effect_generator #(.LED_COUNT(LED_N)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.tick_valid(tick_valid),
		.tick_stall(tick_stall),
		.restart(restart),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.led_index(led_index),
		.pixel_color(pixel_color),
		.last(last),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int effect_period(logic [2:0] m);
		case (m)
			MODE_RUN:     return LED_N;
			MODE_BREATHE: return 512;
			MODE_RAINBOW: return 256;
			MODE_BLINK:   return 2;
			default:      return 1;
		endcase
	endfunction

	function automatic logic [COLOR_W-1:0] shade_of(int led, int e);
		logic [COLOR_W-1:0] c;
		logic [7:0] r, g, b;
		int lvl, wp, w;
		case (fx_mode)
			MODE_RUN: begin
				c = (led == e) ? fx_color : '0;
			end
			MODE_BREATHE: begin
				lvl = (e < 256) ? e : 511 - e;
				r = 8'(int'(fx_color[23:16]) * lvl / 255);
				g = 8'(int'(fx_color[15:8]) * lvl / 255);
				b = 8'(int'(fx_color[7:0]) * lvl / 255);
				c = {r, g, b};
			end
			MODE_RAINBOW: begin
				wp = (led * 256 / LED_N + e) % 256;
				if (wp < 85) begin
					r = 8'(255 - 3 * wp);
					g = 8'(3 * wp);
					b = 8'd0;
				end else if (wp < 170) begin
					w = wp - 85;
					r = 8'd0;
					g = 8'(255 - 3 * w);
					b = 8'(3 * w);
				end else begin
					w = wp - 170;
					r = 8'(3 * w);
					g = 8'd0;
					b = 8'(255 - 3 * w);
				end
				c = {r, g, b};
			end
			MODE_BLINK: begin
				c = (e == 0) ? fx_color : '0;
			end
			default: begin
				c = fx_color;
			end
		endcase
		if (fx_grb)
			c = {c[15:8], c[23:16], c[7:0]};
		return c;
	endfunction

	function automatic logic [COLOR_W-1:0] draw_color();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 24'hFFFFFF;
			default: return COLOR_W'($urandom);
		endcase
	endfunction

	// queue the frame one tick transaction should produce, then step the phase
	task automatic book_frame(bit rs, bit typed, logic [COLOR_W-1:0] want);
		int per, e;
		lamp_t l;
		if (rs)
			fx_phase = 0;
		per = effect_period(fx_mode);
		e = fx_phase % per;
		for (int i = 0; i < LED_N; i++) begin
			l.led = IDX_OUT_W'(i);
			l.color = typed ? want : shade_of(i, e);
			l.last = (i == LED_N - 1);
			lamps_due.push_back(l);
		end
		fx_phase = (e + 1) % per;
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic send_tick(bit rs, bit typed, logic [COLOR_W-1:0] want);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			tick_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		tick_valid <= 1'b1;
		restart <= rs;
		@(posedge clk);
		while (tick_stall)
			@(posedge clk);
		book_frame(rs, typed, want);
		@(negedge clk);
	endtask

	task automatic drain();
		tick_valid <= 1'b0;
		while (lamps_due.size() > 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// registers only change with the pipeline empty
	task automatic set_effect(logic [2:0] m, logic [COLOR_W-1:0] color, bit grb, bit spare);
		drain();
		cfg_write <= 1'b1;
		if (spare) begin
			cfg_index <= CFG_SPARE;
			cfg_data <= COLOR_W'($urandom);
			@(negedge clk);
		end
		cfg_index <= CFG_MODE;
		cfg_data <= COLOR_W'(($urandom << 3) | 32'(m));
		fx_mode = m;
		@(negedge clk);
		cfg_index <= CFG_COLOR;
		cfg_data <= color;
		fx_color = color;
		@(negedge clk);
		cfg_index <= CFG_GRB;
		cfg_data <= COLOR_W'(($urandom << 1) | 32'(grb));
		fx_grb = grb;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic add_step(bit cfg, logic [2:0] m, logic [COLOR_W-1:0] color, bit grb,
			bit rs, bit typed, logic [COLOR_W-1:0] want);
		step_t s;
		s = {cfg, m, color, grb, rs, typed, want};
		plan.push_back(s);
	endtask

	task automatic note_fault(string what, logic [COLOR_W-1:0] want, logic [COLOR_W-1:0] got);
		faults++;
		if (faults <= MAX_SHOWN)
			$display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $time);
	endtask

	// pixel sink and checker
	initial begin
		int hold;
		lamp_t want;
		pixel_stall = 1'b0;
		forever begin
			hold = rx_calm ? 0 : $urandom_range(0, 11);
			@(negedge clk);
			if (hold > 0) begin
				pixel_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			pixel_stall <= 1'b0;
			@(posedge clk);
			while (!pixel_valid)
				@(posedge clk);
			if (lamps_due.size() == 0) begin
				note_fault("stray pixel transaction, led_index", '0, COLOR_W'(led_index));
			end else begin
				want = lamps_due.pop_front();
				if (led_index !== want.led)
					note_fault("led_index", COLOR_W'(want.led), COLOR_W'(led_index));
				if (pixel_color !== want.color)
					note_fault("pixel_color", want.color, pixel_color);
				if (last !== want.last)
					note_fault("last", COLOR_W'(want.last), COLOR_W'(last));
			end
		end
	end

	initial begin
		int n;
		arst_n = 1'b0;
		tick_valid = 1'b0;
		restart = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_MODE;
		cfg_data = '0;
		fx_mode = MODE_SOLID;
		fx_color = '0;
		fx_grb = 1'b0;
		fx_phase = 0;

		// cfg, mode, color, grb, restart, typed, typed color
		add_step(0, MODE_SOLID,   24'h000000, 0, 0, 1, 24'h000000);
		add_step(1, MODE_SOLID,   24'hFFFFFF, 0, 0, 1, 24'hFFFFFF);
		add_step(1, MODE_SOLID,   24'hFF0000, 1, 0, 1, 24'h00FF00);
		add_step(1, MODE_SOLID,   24'h00FF00, 1, 0, 1, 24'hFF0000);
		add_step(1, MODE_SOLID,   24'h0000FF, 1, 0, 1, 24'h0000FF);
		add_step(1, 3'd7,         24'h123456, 0, 0, 1, 24'h123456);
		add_step(1, 3'd5,         24'hABCDEF, 1, 0, 1, 24'hCDABEF);
		add_step(1, MODE_BLINK,   24'hA5A5A5, 0, 1, 1, 24'hA5A5A5);
		add_step(0, MODE_BLINK,   24'hA5A5A5, 0, 0, 1, 24'h000000);
		add_step(0, MODE_BLINK,   24'hA5A5A5, 0, 0, 1, 24'hA5A5A5);
		add_step(1, MODE_RUN,     24'h00FF00, 0, 1, 0, 24'h000000);
		add_step(0, MODE_RUN,     24'h00FF00, 0, 0, 0, 24'h000000);
		add_step(0, MODE_RUN,     24'h00FF00, 0, 0, 0, 24'h000000);
		add_step(0, MODE_RUN,     24'h00FF00, 0, 0, 0, 24'h000000);
		// mode switch with the running light part way along
		add_step(1, MODE_BLINK,   24'h00FF00, 0, 0, 0, 24'h000000);
		add_step(1, MODE_BREATHE, 24'hFFFFFF, 0, 1, 1, 24'h000000);
		add_step(0, MODE_BREATHE, 24'hFFFFFF, 0, 0, 1, 24'h010101);
		add_step(0, MODE_BREATHE, 24'hFFFFFF, 0, 0, 0, 24'h000000);
		add_step(1, MODE_RAINBOW, 24'h000000, 0, 1, 0, 24'h000000);
		add_step(0, MODE_RAINBOW, 24'h000000, 0, 0, 0, 24'h000000);
		add_step(1, MODE_RAINBOW, 24'h000000, 1, 0, 0, 24'h000000);
		add_step(1, 3'd6,         24'hFFFFFF, 0, 1, 1, 24'hFFFFFF);
		add_step(1, MODE_RUN,     24'h800001, 1, 0, 0, 24'h000000);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[k]) begin
			if (plan[k].cfg)
				set_effect(plan[k].mode, plan[k].color, plan[k].grb, 1'b0);
			send_tick(plan[k].rs, plan[k].typed, plan[k].want);
		end

		// one long breathing run up the rising ramp from zero
		set_effect(MODE_BREATHE, draw_color(), 1'($urandom_range(0, 1)), 1'b1);
		for (int k = 0; k < BREATH_RUN; k++) begin
			if (k % 64 == 0) begin
				tx_calm = ($urandom_range(0, 3) == 0);
				rx_calm = ($urandom_range(0, 3) == 0);
			end
			send_tick(k == 0, 1'b0, '0);
		end

		for (int p = 0; p < 18; p++) begin
			set_effect(3'($urandom_range(0, 7)), draw_color(), 1'($urandom_range(0, 1)),
				$urandom_range(0, 3) == 0);
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			n = $urandom_range(1, 9);
			for (int k = 0; k < n; k++)
				send_tick($urandom_range(0, 7) == 0, 1'b0, '0);
		end

		drain();
		repeat (8) @(negedge clk);
		if (faults == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
